// File: hdl/tca_pkg.sv
// Shared types and constants for the toroidal 3D cellular automaton.
// No dependencies; tca_if, tca_acc and the top level import this package.
package tca_pkg;

    // Fixed field widths.
    localparam int COORD_W   = 6;
    localparam int CMD_W     = 2;
    localparam int MASK_W    = 27;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W     = 5;

    // Default grid size.
    localparam int DEF_X_CELLS = 64;
    localparam int DEF_Y_CELLS = 64;
    localparam int DEF_Z_CELLS = 64;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SURVIVE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BIRTH   = 1'b1;

    // Reset rule: born on 4, survive on 4.
    localparam logic [MASK_W-1:0] RESET_RULE = 27'h10;

    // Nine row reads per output row; the step counter runs one past them.
    localparam logic [3:0] ADV_LAST_STEP = 4'd9;

    // Control group from the sequencer to the neighbor counter.
    typedef struct packed {
        logic clear;
        logic add;
        logic center_en;
    } tca_acc_ctrl_t;

endpackage

// File: hdl/tca_if.sv
// Handshake channels of the cellular automaton: command, reply and configuration.
// Depends on tca_pkg.
interface tca_req_if
    import tca_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] cell_z;
    logic               write_alive;

    modport source(output valid, cmd, cell_x, cell_y, cell_z, write_alive, input ready);
    modport sink(input valid, cmd, cell_x, cell_y, cell_z, write_alive, output ready);
endinterface

interface tca_rsp_if
    import tca_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] reply_kind;
    logic             cell_alive;

    modport source(output valid, reply_kind, cell_alive, input ready);
    modport sink(input valid, reply_kind, cell_alive, output ready);
endinterface

interface tca_cfg_if
    import tca_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [MASK_W-1:0]    data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// File: hdl/tca_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tca_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/tca_acc.sv
// Per-column neighbor counters and rule lookup for one row of the grid.
// Depends on tca_pkg.
module tca_acc
    import tca_pkg::*;
#(
    parameter int X_CELLS = DEF_X_CELLS
) (
    input  logic               clk,
    input  tca_acc_ctrl_t      ctrl,
    input  logic [X_CELLS-1:0] row,
    input  logic [MASK_W-1:0]  survive_mask,
    input  logic [MASK_W-1:0]  birth_mask,
    output logic [X_CELLS-1:0] new_row
);

    logic [CNT_W-1:0]   cnt_reg [X_CELLS];
    logic [X_CELLS-1:0] center_reg;

    // The center row is kept to know which cells are alive now.
    always_ff @(posedge clk)
    begin
        if (ctrl.center_en)
        begin
            center_reg <= row;
        end
    end

    for (genvar gx = 0; gx < X_CELLS; gx++)
    begin : g_lane
        localparam int XM = (gx + X_CELLS - 1) % X_CELLS;
        localparam int XP = (gx + 1) % X_CELLS;
        logic [CNT_W-1:0]  n_cnt;
        logic [MASK_W-1:0] rule;

        // Add the three cells of this row that touch column gx, wrapping at the ends.
        always_ff @(posedge clk)
        begin
            if (ctrl.clear)
            begin
                cnt_reg[gx] <= '0;
            end
            else if (ctrl.add)
            begin
                cnt_reg[gx] <= cnt_reg[gx] + CNT_W'(row[XM]) + CNT_W'(row[gx])
                               + CNT_W'(row[XP]);
            end
        end

        // The sum covers the full 3x3x3 block, so the cell itself is taken out.
        always_comb
        begin
            n_cnt       = cnt_reg[gx] - CNT_W'(center_reg[gx]);
            rule        = center_reg[gx] ? survive_mask : birth_mask;
            new_row[gx] = rule[n_cnt];
        end
    end

endmodule

// File: hdl/toroidal_3d_cellular_automaton.sv
// Top level: toroidal 3D life-like cellular automaton with two row-wide grid RAMs.
// Depends on tca_pkg, tca_if, tca_ram and tca_acc.
// A cell read or write passes through CRD, CUSE and RESP; an unused command or bad cell goes to RESP.
// Advance: per grid row, nine row reads of one RAM port in ADV plus a write in ADV_WR,
// for all Y_CELLS*Z_CELLS rows in turn. One item at a time.
// Reset: masks take the born-on-4 / survive-on-4 rule; a clearing pass over all
// Y_CELLS*Z_CELLS rows (4096) zeroes the grid in bank 0 before the first command is taken.
module toroidal_3d_cellular_automaton
    import tca_pkg::*;
#(
    parameter int X_CELLS = DEF_X_CELLS,
    parameter int Y_CELLS = DEF_Y_CELLS,
    parameter int Z_CELLS = DEF_Z_CELLS
) (
    input  logic     clk,
    input  logic     rst_n,
    tca_req_if.sink  req,
    tca_rsp_if.source rsp,
    tca_cfg_if.sink  cfg
);

    localparam int XW    = $clog2(X_CELLS);
    localparam int YW    = $clog2(Y_CELLS);
    localparam int ZW    = $clog2(Z_CELLS);
    localparam int ROWS  = Y_CELLS * Z_CELLS;
    localparam int RW    = $clog2(ROWS);
    localparam int CW_XY = (XW > YW) ? XW : YW;
    localparam int CW_A  = (CW_XY > ZW) ? CW_XY : ZW;
    // One spare bit so that the grid sizes themselves fit for the range check.
    localparam int CW    = ((CW_A > COORD_W) ? CW_A : COORD_W) + 1;

    typedef enum logic [2:0] {CLR, IDLE, CRD, CUSE, ADV, ADV_WR, RESP} state_t;

    state_t             state_reg;
    logic [RW-1:0]      clr_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [XW-1:0]      x_reg;
    logic [YW-1:0]      y_reg;
    logic [ZW-1:0]      z_reg;
    logic               walive_reg;
    logic               alive_reg;
    logic               bank_reg;
    logic [3:0]         step_reg;
    logic [1:0]         sy_reg;
    logic [1:0]         sz_reg;
    logic [MASK_W-1:0]  survive_reg;
    logic [MASK_W-1:0]  birth_reg;
    logic               rsp_valid_reg;
    logic [CMD_W-1:0]   rsp_kind_reg;
    logic               rsp_alive_reg;

    logic [CW-1:0]      xe, ye, ze;
    logic               in_range;
    logic [YW-1:0]      ym1, yp1, ny;
    logic [ZW-1:0]      zm1, zp1, nz;
    logic [RW-1:0]      self_addr, nb_addr, rd_addr, wr_addr;
    logic               wr_en, wr_bank;
    logic [X_CELLS-1:0] wr_data, rd0, rd1, cur_rdata, new_row;
    tca_acc_ctrl_t      acc_ctrl;
    logic               rsp_load;

    function automatic logic [RW-1:0] row_addr(logic [ZW-1:0] z, logic [YW-1:0] y);
        row_addr = RW'(z) * RW'(Y_CELLS) + RW'(y);
    endfunction

    // Coordinate decode and range check of the incoming word.
    assign xe       = CW'(req.cell_x);
    assign ye       = CW'(req.cell_y);
    assign ze       = CW'(req.cell_z);
    assign in_range = (xe < CW'(X_CELLS)) && (ye < CW'(Y_CELLS)) && (ze < CW'(Z_CELLS));

    // Wrapped neighbor rows and plane for the current advance step.
    always_comb
    begin
        ym1 = (y_reg == '0) ? YW'(Y_CELLS - 1) : y_reg - 1'b1;
        yp1 = (y_reg == YW'(Y_CELLS - 1)) ? '0 : y_reg + 1'b1;
        zm1 = (z_reg == '0) ? ZW'(Z_CELLS - 1) : z_reg - 1'b1;
        zp1 = (z_reg == ZW'(Z_CELLS - 1)) ? '0 : z_reg + 1'b1;
        case (sy_reg)
            2'd0:    ny = ym1;
            2'd1:    ny = y_reg;
            default: ny = yp1;
        endcase
        case (sz_reg)
            2'd0:    nz = zm1;
            2'd1:    nz = z_reg;
            default: nz = zp1;
        endcase
    end

    assign self_addr = row_addr(z_reg, y_reg);
    assign nb_addr   = row_addr(nz, ny);
    assign rd_addr   = (state_reg == ADV) ? nb_addr : self_addr;
    assign cur_rdata = bank_reg ? rd1 : rd0;

    // RAM write port: clearing pass, cell write, or new generation row.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_bank = bank_reg;
        wr_addr = self_addr;
        wr_data = cur_rdata;
        case (state_reg)
            CLR:
            begin
                wr_en   = 1'b1;
                wr_bank = 1'b0;
                wr_addr = clr_reg;
                wr_data = '0;
            end
            CUSE:
            begin
                wr_en          = (cmd_reg == CMD_WRITE);
                wr_data[x_reg] = walive_reg;
            end
            ADV_WR:
            begin
                wr_en   = 1'b1;
                wr_bank = !bank_reg;
                wr_data = new_row;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    tca_ram #(.WIDTH(X_CELLS), .DEPTH(ROWS)) u_ram0 (
        .clk  (clk),
        .we   (wr_en && !wr_bank),
        .waddr(wr_addr),
        .wdata(wr_data),
        .raddr(rd_addr),
        .rdata(rd0)
    );

    tca_ram #(.WIDTH(X_CELLS), .DEPTH(ROWS)) u_ram1 (
        .clk  (clk),
        .we   (wr_en && wr_bank),
        .waddr(wr_addr),
        .wdata(wr_data),
        .raddr(rd_addr),
        .rdata(rd1)
    );

    // Neighbor counter control: clear on the first step, add as row data returns.
    always_comb
    begin
        acc_ctrl.clear     = (state_reg == ADV) && (step_reg == '0);
        acc_ctrl.add       = (state_reg == ADV) && (step_reg != '0);
        acc_ctrl.center_en = (state_reg == ADV) && (step_reg == 4'd5);
    end

    tca_acc #(.X_CELLS(X_CELLS)) u_acc (
        .clk         (clk),
        .ctrl        (acc_ctrl),
        .row         (cur_rdata),
        .survive_mask(survive_reg),
        .birth_mask  (birth_reg),
        .new_row     (new_row)
    );

    // Handshakes.
    assign req.ready      = (state_reg == IDLE);
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.reply_kind = rsp_kind_reg;
    assign rsp.cell_alive = rsp_alive_reg;
    assign rsp_load       = (state_reg == RESP) && (!rsp_valid_reg || rsp.ready);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            survive_reg <= RESET_RULE;
            birth_reg   <= RESET_RULE;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SURVIVE: survive_reg <= cfg.data;
                REG_BIRTH:   birth_reg   <= cfg.data;
                default:     survive_reg <= survive_reg;
            endcase
        end
    end

    // Sequencer and reply register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CLR;
            clr_reg       <= '0;
            bank_reg      <= 1'b0;
            step_reg      <= '0;
            sy_reg        <= '0;
            sz_reg        <= '0;
            rsp_valid_reg <= 1'b0;
            cmd_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            walive_reg    <= 1'b0;
            alive_reg     <= 1'b0;
            rsp_kind_reg  <= '0;
            rsp_alive_reg <= 1'b0;
        end
        else
        begin
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_kind_reg  <= cmd_reg;
                rsp_alive_reg <= alive_reg;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == RW'(ROWS - 1))
                    begin
                        state_reg <= IDLE;
                    end
                end
                IDLE:
                begin
                    if (req.valid)
                    begin
                        cmd_reg    <= req.cmd;
                        x_reg      <= xe[XW-1:0];
                        walive_reg <= req.write_alive;
                        alive_reg  <= 1'b0;
                        step_reg   <= '0;
                        sy_reg     <= '0;
                        sz_reg     <= '0;
                        case (req.cmd)
                            CMD_WRITE, CMD_READ:
                            begin
                                y_reg     <= ye[YW-1:0];
                                z_reg     <= ze[ZW-1:0];
                                state_reg <= in_range ? CRD : RESP;
                            end
                            CMD_ADVANCE:
                            begin
                                y_reg     <= '0;
                                z_reg     <= '0;
                                state_reg <= ADV;
                            end
                            default:
                            begin
                                state_reg <= RESP;
                            end
                        endcase
                    end
                end
                CRD:
                begin
                    state_reg <= CUSE;
                end
                CUSE:
                begin
                    if (cmd_reg == CMD_READ)
                    begin
                        alive_reg <= cur_rdata[x_reg];
                    end
                    state_reg <= RESP;
                end
                ADV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (sy_reg == 2'd2)
                    begin
                        sy_reg <= '0;
                        sz_reg <= sz_reg + 1'b1;
                    end
                    else
                    begin
                        sy_reg <= sy_reg + 1'b1;
                    end
                    if (step_reg == ADV_LAST_STEP)
                    begin
                        state_reg <= ADV_WR;
                    end
                end
                ADV_WR:
                begin
                    step_reg <= '0;
                    sy_reg   <= '0;
                    sz_reg   <= '0;
                    if (y_reg == YW'(Y_CELLS - 1))
                    begin
                        y_reg <= '0;
                        if (z_reg == ZW'(Z_CELLS - 1))
                        begin
                            z_reg     <= '0;
                            bank_reg  <= !bank_reg;
                            state_reg <= RESP;
                        end
                        else
                        begin
                            z_reg     <= z_reg + 1'b1;
                            state_reg <= ADV;
                        end
                    end
                    else
                    begin
                        y_reg     <= y_reg + 1'b1;
                        state_reg <= ADV;
                    end
                end
                RESP:
                begin
                    if (rsp_load)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    // The grid is never touched by a command while the clearing pass runs.
    a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CLR) |-> !req.ready)
        else $error("command accepted during clearing pass");

    // The active bank changes only at the end of the last row of an advance.
    a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (bank_reg != $past(bank_reg)) |-> ($past(state_reg) == ADV_WR))
        else $error("bank switched outside an advance");

    // The step counter of an advance row never passes the nine reads plus one drain step.
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ADV) |-> (step_reg <= ADV_LAST_STEP))
        else $error("advance step counter overran");

    // A reply is loaded only when the reply register is free or being drained.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |=> (rsp_kind_reg == $past(rsp_kind_reg)))
        else $error("pending reply overwritten");

endmodule
